// File: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared constants, codes and a day-rule helper for the timed event table scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  // field widths
  localparam int ACTION_W = 2;
  localparam int ID_W     = 8;
  localparam int DAY_W    = 4;
  localparam int MINUTE_W = 11;
  localparam int TODAY_W  = 3;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int TARGET_W = 7;

  // parameter defaults
  localparam int EVENT_SLOTS_DEF = 32;
  localparam int LIGHTS_DEF      = 32;

  // request codes
  localparam logic [ACTION_W-1:0] ACT_ADD_ON  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_OFF = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ON     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OFF    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // day rules beyond the single weekdays
  localparam logic [DAY_W-1:0] RULE_EVERY    = 4'd7;
  localparam logic [DAY_W-1:0] RULE_WEEKDAYS = 4'd8;
  localparam logic [DAY_W-1:0] RULE_WEEKEND  = 4'd9;

  localparam logic [TODAY_W-1:0] DAY_SUNDAY   = 3'd0;
  localparam logic [TODAY_W-1:0] DAY_MONDAY   = 3'd1;
  localparam logic [TODAY_W-1:0] DAY_FRIDAY   = 3'd5;
  localparam logic [TODAY_W-1:0] DAY_SATURDAY = 3'd6;

  function automatic logic rule_matches(input logic [DAY_W-1:0] rule,
                                        input logic [TODAY_W-1:0] today);
    logic hit;
    if (rule == RULE_WEEKEND) begin
      hit = (today == DAY_SUNDAY) || (today == DAY_SATURDAY);
    end else if (rule == RULE_WEEKDAYS) begin
      hit = (today >= DAY_MONDAY) && (today <= DAY_FRIDAY);
    end else begin
      hit = (rule == {1'b0, today}) || (rule == RULE_EVERY);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: rtl/timed_event_table_scheduler_top.sv
// ----------------------------------------------------------------------------
// timed_event_table_scheduler_top
// Light event table: add, remove and per-minute tick scan over a slot memory.
// ----------------------------------------------------------------------------
// Flow, input transfer to final result: an add with a bad id answers straight from idle;
//   an add walks the valid bits to the first free slot; a remove or a tick reads the
//   slots in turn (one slot read per cycle), then the read register, end, output reg.
// Occupancy: one item at a time; the next transfer can land on the edge that takes
//   the final result.
// Reset: synchronous; valid bits clear at reset, no clearing pass; no stall input.
`default_nettype none

module timed_event_table_scheduler_top
  import tes_pkg::*;
#(
  parameter int EVENT_SLOTS = EVENT_SLOTS_DEF,
  parameter int LIGHTS      = LIGHTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ACTION_W-1:0]        in_action,
  input  wire logic signed [ID_W-1:0]     in_light_id,
  input  wire logic [DAY_W-1:0]           in_day_code,
  input  wire logic [MINUTE_W-1:0]        in_minute,
  input  wire logic [TODAY_W-1:0]         in_current_day,
  output logic                            out_valid,
  output logic [KIND_W-1:0]               out_kind,
  output logic [STATUS_W-1:0]             out_status,
  output logic [TARGET_W-1:0]             out_target_light,
  output logic                            out_last
);

  localparam int ADDR_W  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CNT_W   = $clog2(EVENT_SLOTS + 1);
  localparam int LIGHT_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
  localparam int ENTRY_W = LIGHT_W + DAY_W + MINUTE_W + 1;

  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(EVENT_SLOTS);
  localparam logic [ID_W-1:0]  LIGHTS_C = ID_W'(LIGHTS);

  // entry layout: {turns_off, light, rule, minute}
  localparam int MIN_LO   = 0;
  localparam int RULE_LO  = MINUTE_W;
  localparam int LIGHT_LO = MINUTE_W + DAY_W;
  localparam int OFF_BIT  = MINUTE_W + DAY_W + LIGHT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [ACTION_W-1:0]    op_r, op_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [DAY_W-1:0]       day_r, day_nxt;
  logic [MINUTE_W-1:0]    min_r, min_nxt;
  logic [TODAY_W-1:0]     today_r, today_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   rd_en_r, rd_en_nxt;
  logic [EVENT_SLOTS-1:0] slot_valid_r, slot_valid_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [TARGET_W-1:0]    out_light_r, out_light_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [ENTRY_W-1:0]     slot_mem [EVENT_SLOTS];
  logic [ENTRY_W-1:0]     rd_data_r;
  logic [ADDR_W-1:0]      rd_idx_r;
  logic                   rd_vld_r;

  logic                   accept;
  logic                   id_bad;
  logic [ADDR_W-1:0]      cnt_idx;
  logic                   rd_issue;
  logic                   wr_en;
  logic [ENTRY_W-1:0]     wr_data;

  logic [LIGHT_W-1:0]     rd_light;
  logic [DAY_W-1:0]       rd_rule;
  logic [MINUTE_W-1:0]    rd_minute;
  logic                   rd_off;
  logic                   tick_due;
  logic                   rm_hit;

  assign accept  = start && (state_r == S_IDLE);
  assign id_bad  = in_light_id[ID_W-1] || ({1'b0, in_light_id[ID_W-2:0]} >= LIGHTS_C);
  assign cnt_idx = cnt_r[ADDR_W-1:0];

  assign rd_light  = rd_data_r[LIGHT_LO +: LIGHT_W];
  assign rd_rule   = rd_data_r[RULE_LO +: DAY_W];
  assign rd_minute = rd_data_r[MIN_LO +: MINUTE_W];
  assign rd_off    = rd_data_r[OFF_BIT];

  assign tick_due = rd_vld_r && (rd_minute == min_r) && rule_matches(rd_rule, today_r);
  // a negative request id has its top bit set and can never equal a stored light
  assign rm_hit   = rd_vld_r && (ID_W'(rd_light) == id_r) && (rd_rule == day_r)
                    && (rd_minute == min_r);

  assign wr_data = {(op_r == ACT_ADD_OFF), id_r[LIGHT_W-1:0], day_r, min_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    day_nxt        = day_r;
    min_nxt        = min_r;
    today_nxt      = today_r;
    cnt_nxt        = cnt_r;
    rd_en_nxt      = 1'b0;
    slot_valid_nxt = slot_valid_r;
    rd_issue       = 1'b0;
    wr_en          = 1'b0;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = KIND_STATUS;
    out_status_nxt = ST_OK;
    out_light_nxt  = '0;
    out_last_nxt   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_action;
          id_nxt    = in_light_id;
          day_nxt   = in_day_code;
          min_nxt   = in_minute;
          today_nxt = in_current_day;
          cnt_nxt   = '0;
          if (in_action == ACT_ADD_ON || in_action == ACT_ADD_OFF) begin
            if (id_bad) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_BOUNDS;
              out_last_nxt   = 1'b1;
            end else begin
              state_nxt = S_ADD;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_ADD: begin
        // walk valid bits for the lowest free slot
        if (cnt_r == SLOTS_C) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!slot_valid_r[cnt_idx]) begin
          wr_en                   = 1'b1;
          slot_valid_nxt[cnt_idx] = 1'b1;
          out_valid_nxt           = 1'b1;
          out_status_nxt          = ST_OK;
          out_last_nxt            = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        // issue stage: one memory read per cycle
        if (cnt_r != SLOTS_C) begin
          rd_issue  = 1'b1;
          rd_en_nxt = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
        // compare stage on last cycle's read
        if (rd_en_r) begin
          if (op_r == ACT_TICK) begin
            if (tick_due) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = rd_off ? KIND_OFF : KIND_ON;
              out_light_nxt = TARGET_W'(rd_light);
            end
          end else if (rm_hit) begin
            // first match only: drop the read already in flight
            slot_valid_nxt[rd_idx_r] = 1'b0;
            out_valid_nxt            = 1'b1;
            out_status_nxt           = ST_OK;
            out_last_nxt             = 1'b1;
            rd_en_nxt                = 1'b0;
            state_nxt                = S_IDLE;
          end
        end else if (cnt_r == SLOTS_C) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          if (op_r == ACT_TICK) begin
            out_kind_nxt = KIND_END;
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_en_r      <= 1'b0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_en_r      <= rd_en_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    day_r        <= day_nxt;
    min_r        <= min_nxt;
    today_r      <= today_nxt;
    cnt_r        <= cnt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_light_r  <= out_light_nxt;
    out_last_r   <= out_last_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[cnt_idx] <= wr_data;
    end
    if (rd_issue) begin
      rd_data_r <= slot_mem[cnt_idx];
      rd_idx_r  <= cnt_idx;
      rd_vld_r  <= slot_valid_r[cnt_idx];
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_target_light = out_light_r;
  assign out_last         = out_last_r;

  // an accepted item is either being worked on or has its result next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid_r))
    else $error("accepted item dropped");

  // adds only write into a free slot
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !slot_valid_r[cnt_idx])
    else $error("add overwrote a valid slot");

  // no read result pending while idle
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !rd_en_r)
    else $error("read in flight while idle");

  // end marker closes the tick; switch commands never do
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r == KIND_STATUS || out_kind_r == KIND_END)))
    else $error("last flag wrong for result kind");

  // a final result always frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == S_IDLE))
    else $error("final result while still busy");

endmodule

`default_nettype wire
